/* src/bfs_pkg.sv */
// Shared types, widths and helpers for the barycentric fragment shader.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps
package bfs_pkg;

	localparam int COORD_BITS       = 16;
	localparam int WEIGHT_FRAC_BITS = 16;

	localparam int CW = (COORD_BITS < 16) ? COORD_BITS : 16;
	localparam int DW = CW + 1;
	localparam int PW = 2 * DW;
	localparam int EW = PW;
	localparam int F  = WEIGHT_FRAC_BITS;
	localparam int WW = F + 1;

	localparam logic [WW-1:0] ONE_W = {1'b1, {F{1'b0}}};

	typedef enum logic [2:0] {
		REG_A_PLACE = 3'd0,
		REG_B_PLACE = 3'd1,
		REG_C_PLACE = 3'd2,
		REG_A_SHADE = 3'd3,
		REG_B_SHADE = 3'd4,
		REG_C_SHADE = 3'd5
	} bfs_reg_t;

	typedef struct packed {
		logic signed [15:0] pixel_x;
		logic signed [15:0] pixel_y;
	} bfs_pixel_t;

	typedef struct packed {
		logic signed [15:0] out_x;
		logic signed [15:0] out_y;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic signed [31:0] depth;
	} bfs_frag_t;

	typedef struct packed {
		logic signed [DW-1:0] cy0;
		logic signed [DW-1:0] cx0;
		logic signed [DW-1:0] cy1;
		logic signed [DW-1:0] cx1;
		logic signed [DW-1:0] x2;
		logic signed [DW-1:0] y2;
		logic [EW-1:0]        dabs;
		logic [2:0][31:0]     z;
		logic [2:0][47:0]     shade;
	} bfs_geom_t;

	typedef struct packed {
		logic          vld;
		bfs_pixel_t    pos;
		logic          sat0;
		logic          sat1;
		logic          zero0;
		logic          zero1;
		logic [EW-1:0] d;
		logic [EW-1:0] rem0;
		logic [EW-1:0] rem1;
		logic [F-1:0]  q0;
		logic [F-1:0]  q1;
	} bfs_div_t;

	function automatic logic signed [DW-1:0] coord(input logic [15:0] slot);
		return DW'($signed(slot[CW-1:0]));
	endfunction

	function automatic logic [EW-1:0] mag(input logic signed [EW:0] v);
		logic signed [EW:0] n;
		n = (v < 0) ? -v : v;
		return n[EW-1:0];
	endfunction

endpackage

/* src/barycentric_fragment_shade.sv */
// Top level of the barycentric fragment shader.
// Depends on bfs_pkg, bfs_setup, bfs_edge, bfs_div and bfs_blend.
`timescale 1ns / 1ps
// Takes one pixel per clock unless the output is stalled, and returns it with
// colour and depth blended from the three configured vertices. The divider
// resolves one weight bit per stage. The whole pipeline holds when the output
// is stalled. After a register write the triangle divisor is recomputed through
// registered products, sum and magnitude; write registers only while empty.
module barycentric_fragment_shade (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_addr,
	input  logic [63:0]         cfg_data,
	input  logic                pixel_valid,
	output logic                pixel_ready,
	input  bfs_pkg::bfs_pixel_t  pixel,
	output logic                frag_valid,
	input  logic                frag_ready,
	output bfs_pkg::bfs_frag_t   frag
);
	import bfs_pkg::*;

	logic      adv;
	bfs_geom_t geom;
	bfs_div_t  edge_out;
	bfs_div_t  div_out;

	assign adv         = !frag_valid || frag_ready;
	assign pixel_ready = adv;

	bfs_setup u_setup (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.geom     (geom)
	);

	bfs_edge u_edge (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.in_vld (pixel_valid),
		.pixel  (pixel),
		.geom   (geom),
		.dout   (edge_out)
	);

	bfs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.din    (edge_out),
		.dout   (div_out)
	);

	bfs_blend u_blend (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.din        (div_out),
		.geom       (geom),
		.frag_valid (frag_valid),
		.frag       (frag)
	);

`ifndef ASSERT_OFF
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		frag_valid && !frag_ready |-> !pixel_ready)
		else $error("pixel taken while output transaction stalled");

	a_weight_flags: assert property (@(posedge clk) disable iff (!arst_n)
		div_out.vld |-> !(div_out.sat0 && div_out.zero0) && !(div_out.sat1 && div_out.zero1))
		else $error("weight both saturated and zero");
`endif

endmodule

/* src/bfs_setup.sv */
// Vertex registers and triangle divisor for the fragment shader.
// Depends on bfs_pkg.
`timescale 1ns / 1ps
module bfs_setup (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_addr,
	input  logic [63:0]       cfg_data,
	output bfs_pkg::bfs_geom_t geom
);
	import bfs_pkg::*;

	logic [2:0][63:0] place_q;
	logic [2:0][47:0] shade_q;
	logic signed [DW-1:0] x0, y0, x1, y1, x2, y2;
	logic signed [PW-1:0] pa_q, pb_q;
	logic signed [PW:0]   dsum_q;
	logic [EW-1:0]        dabs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			place_q <= '0;
			shade_q <= '0;
		end else if (cfg_we) begin
			case (bfs_reg_t'(cfg_addr))
				REG_A_PLACE: place_q[0] <= cfg_data;
				REG_B_PLACE: place_q[1] <= cfg_data;
				REG_C_PLACE: place_q[2] <= cfg_data;
				REG_A_SHADE: shade_q[0] <= cfg_data[47:0];
				REG_B_SHADE: shade_q[1] <= cfg_data[47:0];
				REG_C_SHADE: shade_q[2] <= cfg_data[47:0];
				default: ;
			endcase
		end
	end

	assign x0 = coord(place_q[0][15:0]);
	assign y0 = coord(place_q[0][31:16]);
	assign x1 = coord(place_q[1][15:0]);
	assign y1 = coord(place_q[1][31:16]);
	assign x2 = coord(place_q[2][15:0]);
	assign y2 = coord(place_q[2][31:16]);

	// divisor follows the registers via registered products, sum and magnitude
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pa_q   <= '0;
			pb_q   <= '0;
			dsum_q <= '0;
			dabs_q <= '0;
		end else begin
			pa_q   <= PW'(y1 - y2) * PW'(x0 - x2);
			pb_q   <= PW'(x2 - x1) * PW'(y0 - y2);
			dsum_q <= (PW+1)'(pa_q) + (PW+1)'(pb_q);
			dabs_q <= mag(dsum_q);
		end
	end

	always_comb begin
		geom.cy0  = y1 - y2;
		geom.cx0  = x2 - x1;
		geom.cy1  = y2 - y0;
		geom.cx1  = x0 - x2;
		geom.x2   = x2;
		geom.y2   = y2;
		geom.dabs = dabs_q;
		for (int k = 0; k < 3; k++) begin
			geom.z[k]     = place_q[k][63:32];
			geom.shade[k] = shade_q[k];
		end
	end

endmodule

/* src/bfs_edge.sv */
// Edge function stages: offsets, products, sums and magnitudes.
// Depends on bfs_pkg; feeds bfs_div.
`timescale 1ns / 1ps
module bfs_edge (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  bfs_pkg::bfs_pixel_t pixel,
	input  bfs_pkg::bfs_geom_t  geom,
	output bfs_pkg::bfs_div_t   dout
);
	import bfs_pkg::*;

	logic v_s1, v_s2, v_s3;
	bfs_pixel_t pos_s1, pos_s2, pos_s3;
	logic signed [DW-1:0] dx_s1, dy_s1;
	logic signed [PW-1:0] a0_s2, b0_s2, a1_s2, b1_s2;
	logic signed [PW:0]   e0_s3, e1_s3;
	bfs_div_t out_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			out_s4.vld <= 1'b0;
		end else if (en) begin
			v_s1   <= in_vld;
			pos_s1 <= pixel;
			dx_s1  <= coord(pixel.pixel_x) - geom.x2;
			dy_s1  <= coord(pixel.pixel_y) - geom.y2;

			v_s2   <= v_s1;
			pos_s2 <= pos_s1;
			a0_s2  <= PW'(geom.cy0) * PW'(dx_s1);
			b0_s2  <= PW'(geom.cx0) * PW'(dy_s1);
			a1_s2  <= PW'(geom.cy1) * PW'(dx_s1);
			b1_s2  <= PW'(geom.cx1) * PW'(dy_s1);

			v_s3   <= v_s2;
			pos_s3 <= pos_s2;
			e0_s3  <= (PW+1)'(a0_s2) + (PW+1)'(b0_s2);
			e1_s3  <= (PW+1)'(a1_s2) + (PW+1)'(b1_s2);

			out_s4.vld   <= v_s3;
			out_s4.pos   <= pos_s3;
			out_s4.sat0  <= 1'b0;
			out_s4.sat1  <= 1'b0;
			out_s4.zero0 <= 1'b0;
			out_s4.zero1 <= 1'b0;
			out_s4.d     <= geom.dabs;
			out_s4.rem0  <= mag(e0_s3);
			out_s4.rem1  <= mag(e1_s3);
			out_s4.q0    <= '0;
			out_s4.q1    <= '0;
		end
	end

	assign dout = out_s4;

endmodule

/* src/bfs_div.sv */
// Pipelined restoring divider for both edge weights, one quotient bit per stage.
// Depends on bfs_pkg; fed by bfs_edge, feeds bfs_blend.
`timescale 1ns / 1ps
module bfs_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  bfs_pkg::bfs_div_t din,
	output bfs_pkg::bfs_div_t dout
);
	import bfs_pkg::*;

	bfs_div_t div_s [F];
	bfs_div_t nxt   [F];

	always_comb begin
		bfs_div_t   p;
		logic [EW:0] t0, t1;
		for (int k = 0; k < F; k++) begin
			p = (k == 0) ? din : div_s[(k == 0) ? 0 : k-1];
			nxt[k] = p;
			if (k == 0) begin
				nxt[k].sat0  = (p.rem0 >= p.d) && (p.rem0 != '0);
				nxt[k].sat1  = (p.rem1 >= p.d) && (p.rem1 != '0);
				nxt[k].zero0 = (p.rem0 == '0);
				nxt[k].zero1 = (p.rem1 == '0);
			end
			t0 = {p.rem0, 1'b0};
			t1 = {p.rem1, 1'b0};
			if (t0 >= {1'b0, p.d}) begin
				nxt[k].rem0 = EW'(t0 - {1'b0, p.d});
				nxt[k].q0   = {p.q0[F-2:0], 1'b1};
			end else begin
				nxt[k].rem0 = t0[EW-1:0];
				nxt[k].q0   = {p.q0[F-2:0], 1'b0};
			end
			if (t1 >= {1'b0, p.d}) begin
				nxt[k].rem1 = EW'(t1 - {1'b0, p.d});
				nxt[k].q1   = {p.q1[F-2:0], 1'b1};
			end else begin
				nxt[k].rem1 = t1[EW-1:0];
				nxt[k].q1   = {p.q1[F-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < F; k++) div_s[k].vld <= 1'b0;
		end else if (en) begin
			for (int k = 0; k < F; k++) div_s[k] <= nxt[k];
		end
	end

	assign dout = div_s[F-1];

endmodule

/* src/bfs_blend.sv */
// Weight clamp, colour and depth blend, and the output register.
// Depends on bfs_pkg; fed by bfs_div and bfs_setup.
`timescale 1ns / 1ps
module bfs_blend (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  bfs_pkg::bfs_div_t   din,
	input  bfs_pkg::bfs_geom_t  geom,
	output logic               frag_valid,
	output bfs_pkg::bfs_frag_t  frag
);
	import bfs_pkg::*;

	localparam int CPW = WW + 16;
	localparam int CSW = WW + 18;
	localparam int SCW = CSW + 8;
	localparam int ZPW = WW + 33;
	localparam int ZSW = WW + 35;

	logic [WW-1:0] w0, w1, w2;
	logic signed [WW+1:0] w2t;

	logic v_s1, v_s2, v_s3, v_s4;
	bfs_pixel_t pos_s1, pos_s2, pos_s3;
	logic [2:0][WW-1:0] w_s1;
	logic [2:0][2:0][CPW-1:0] cp_s2;
	logic signed [ZPW-1:0] zp_s2 [3];
	logic [2:0][CSW-1:0] cs_s3;
	logic signed [ZSW-1:0] zs_s3;
	bfs_frag_t frag_s4;

	logic [2:0][7:0] chan;
	logic [SCW-1:0] sc [3];
	logic signed [ZSW-1:0] zsh;
	logic signed [31:0] dep;

	always_comb begin
		w0  = din.zero0 ? '0 : (din.sat0 ? ONE_W : {1'b0, din.q0});
		w1  = din.zero1 ? '0 : (din.sat1 ? ONE_W : {1'b0, din.q1});
		w2t = $signed({2'b0, ONE_W}) - $signed({2'b0, w0}) - $signed({2'b0, w1});
		w2  = (w2t < 0) ? '0 : w2t[WW-1:0];
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sc[c] = {cs_s3[c], 8'b0} - SCW'(cs_s3[c]);
			if (sc[c][SCW-1:F+16] > (SCW-F-16)'(255)) chan[c] = 8'hFF;
			else chan[c] = sc[c][F+23:F+16];
		end
		zsh = zs_s3 >>> F;
		if (zsh[ZSW-1:31] == '0 || zsh[ZSW-1:31] == '1) dep = zsh[31:0];
		else dep = zsh[ZSW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1   <= din.vld;
			pos_s1 <= din.pos;
			w_s1   <= {w2, w1, w0};

			v_s2   <= v_s1;
			pos_s2 <= pos_s1;
			for (int k = 0; k < 3; k++) begin
				for (int c = 0; c < 3; c++)
					cp_s2[c][k] <= CPW'(w_s1[k]) * CPW'(geom.shade[k][16*c +: 16]);
				zp_s2[k] <= ZPW'($signed({1'b0, w_s1[k]})) * ZPW'($signed(geom.z[k]));
			end

			v_s3   <= v_s2;
			pos_s3 <= pos_s2;
			for (int c = 0; c < 3; c++)
				cs_s3[c] <= CSW'(cp_s2[c][0]) + CSW'(cp_s2[c][1]) + CSW'(cp_s2[c][2]);
			zs_s3 <= ZSW'(zp_s2[0]) + ZSW'(zp_s2[1]) + ZSW'(zp_s2[2]);

			v_s4          <= v_s3;
			frag_s4.out_x <= pos_s3.pixel_x;
			frag_s4.out_y <= pos_s3.pixel_y;
			frag_s4.red   <= chan[0];
			frag_s4.green <= chan[1];
			frag_s4.blue  <= chan[2];
			frag_s4.depth <= dep;
		end
	end

	assign frag_valid = v_s4;
	assign frag       = frag_s4;

endmodule

/* dv/barycentric_fragment_shade_tb.sv */
// Self-checking testbench for barycentric_fragment_shade: directed table, then random
// triangles and pixels, checked against typed values or an interpolation predictor.
// Depends on bfs_pkg and the barycentric_fragment_shade RTL.
`timescale 1ns / 1ps
module barycentric_fragment_shade_tb;
	import bfs_pkg::*;

	localparam logic [2:0] REG_BAD_LO = 3'd6;
	localparam logic [2:0] REG_BAD_HI = 3'd7;
	localparam longint UNIT_W = longint'(1) << WEIGHT_FRAC_BITS;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		bfs_pixel_t pix;
		bit         typed;
		bfs_frag_t  frag;
	} pix_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_addr = '0;
	logic [63:0] cfg_data = '0;
	logic        pixel_valid = 1'b0;
	logic        pixel_ready;
	bfs_pixel_t  pixel = '0;
	logic        frag_valid;
	logic        frag_ready = 1'b0;
	bfs_frag_t   frag;

	logic [63:0] vert_place [3];
	logic [47:0] vert_shade [3];
	longint      tri_area;
	bfs_frag_t   frag_expected [$];
	int          n_frags = 0;
	int          n_errors = 0;
	int          n_phases = 0;
	bit          no_idle = 1'b0;
	bit          hold_long = 1'b0;

	barycentric_fragment_shade i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
		.cfg_data(cfg_data), .pixel_valid(pixel_valid), .pixel_ready(pixel_ready),
		.pixel(pixel), .frag_valid(frag_valid), .frag_ready(frag_ready), .frag(frag)
	);

	always #5 clk = ~clk;

	function automatic longint vx(int k);
		return longint'($signed(vert_place[k][15:0]));
	endfunction

	function automatic longint vy(int k);
		return longint'($signed(vert_place[k][31:16]));
	endfunction

	function automatic longint vz(int k);
		return longint'($signed(vert_place[k][63:32]));
	endfunction

	function automatic longint edge_weight(longint e_val);
		longint e;
		longint d;
		longint q;
		e = (e_val < 0) ? -e_val : e_val;
		d = (tri_area < 0) ? -tri_area : tri_area;
		if (d == 0)
			return (e != 0) ? UNIT_W : 0;
		q = (e << WEIGHT_FRAC_BITS) / d;
		return (q > UNIT_W) ? UNIT_W : q;
	endfunction

	function automatic logic [7:0] blend_channel(longint w [3], int sh);
		longint s;
		longint r;
		s = 0;
		for (int k = 0; k < 3; k++)
			s += w[k] * longint'((vert_shade[k] >> sh) & 48'hFFFF);
		r = (s * 255) >>> (WEIGHT_FRAC_BITS + 16);
		return (r > 255) ? 8'd255 : r[7:0];
	endfunction

	function automatic bfs_frag_t shade_fragment(bfs_pixel_t p);
		longint dx;
		longint dy;
		longint w [3];
		longint acc;
		longint dep;
		bfs_frag_t f;
		dx = longint'(p.pixel_x) - vx(2);
		dy = longint'(p.pixel_y) - vy(2);
		w[0] = edge_weight((vy(1) - vy(2)) * dx + (vx(2) - vx(1)) * dy);
		w[1] = edge_weight((vy(2) - vy(0)) * dx + (vx(0) - vx(2)) * dy);
		w[2] = UNIT_W - w[0] - w[1];
		if (w[2] < 0)
			w[2] = 0;
		acc = 0;
		for (int k = 0; k < 3; k++)
			acc += w[k] * vz(k);
		dep = acc >>> WEIGHT_FRAC_BITS;
		if (dep > 64'sd2147483647)
			dep = 64'sd2147483647;
		if (dep < -64'sd2147483648)
			dep = -64'sd2147483648;
		f.out_x = p.pixel_x;
		f.out_y = p.pixel_y;
		f.red   = blend_channel(w, 0);
		f.green = blend_channel(w, 16);
		f.blue  = blend_channel(w, 32);
		f.depth = dep[31:0];
		return f;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx <= REG_C_PLACE)
			vert_place[idx] = val;
		else if (idx <= REG_C_SHADE)
			vert_shade[idx - REG_A_SHADE] = val[47:0];
		if (idx <= REG_C_SHADE)
			tri_area = (vy(1) - vy(2)) * (vx(0) - vx(2)) + (vx(2) - vx(1)) * (vy(0) - vy(2));
	endtask

	task automatic drain();
		pixel_valid <= 1'b0;
		while (frag_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_triangle(logic [63:0] pa, logic [63:0] pb, logic [63:0] pc,
			logic [47:0] sa, logic [47:0] sb, logic [47:0] sc);
		drain();
		write_reg(REG_A_PLACE, pa);
		write_reg(REG_B_PLACE, pb);
		write_reg(REG_C_PLACE, pc);
		write_reg(REG_A_SHADE, {16'h0, sa});
		write_reg(REG_B_SHADE, {16'h0, sb});
		write_reg(REG_C_SHADE, {16'h0, sc});
		write_reg(($urandom_range(0, 1) != 0) ? REG_BAD_LO : REG_BAD_HI,
			{$urandom, $urandom});
		cfg_we <= 1'b0;
		repeat (8) @(posedge clk);
		n_phases++;
	endtask

	task automatic send_pixel(bfs_pixel_t p, bit typed, bfs_frag_t f);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel       <= p;
		do @(posedge clk); while (!pixel_ready);
		frag_expected.push_back(typed ? f : shade_fragment(p));
	endtask

	function automatic logic [63:0] place(int x, int y, int z);
		return {z[31:0], y[15:0], x[15:0]};
	endfunction

	function automatic bfs_pixel_t pix(int x, int y);
		bfs_pixel_t p;
		p.pixel_x = x[15:0];
		p.pixel_y = y[15:0];
		return p;
	endfunction

	// receiver: random stalls, one long hold-off on request
	initial begin
		int stall;
		bfs_frag_t want;
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 7);
			if (hold_long) begin
				stall = 300;
				hold_long = 1'b0;
			end
			if (stall > 0) begin
				frag_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			frag_ready <= 1'b1;
			do @(posedge clk); while (!frag_valid);
			n_frags++;
			if (frag_expected.size() == 0) begin
				$display("%0t: unexpected transaction, actual %p", $time, frag);
				n_errors++;
			end else begin
				want = frag_expected.pop_front();
				if (frag.out_x !== want.out_x || frag.out_y !== want.out_y ||
						frag.red !== want.red || frag.green !== want.green ||
						frag.blue !== want.blue || frag.depth !== want.depth) begin
					$display("%0t: mismatch expected %p actual %p", $time, want, frag);
					n_errors++;
				end
			end
		end
	end

	initial begin
		#2ms;
		$display("FAIL");
		$finish;
	end

	initial begin
		pix_row_t rows [$];
		pix_row_t r;
		int mode;
		int span;
		logic [63:0] p0;
		for (int k = 0; k < 3; k++) begin
			vert_place[k] = '0;
			vert_shade[k] = '0;
		end
		tri_area = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// after reset: zero divisor, zero edges, all weight on the third vertex
		r.typed = 1'b1;
		r.pix = pix(0, 0);           rows.push_back(r);
		r.pix = pix(32767, -32768);  rows.push_back(r);
		r.pix = pix(-32768, 32767);  rows.push_back(r);
		r.pix = pix(-1, -1);         rows.push_back(r);
		r.pix = pix(21845, -21846);  rows.push_back(r);
		foreach (rows[i]) begin
			rows[i].frag = '0;
			rows[i].frag.out_x = rows[i].pix.pixel_x;
			rows[i].frag.out_y = rows[i].pix.pixel_y;
			send_pixel(rows[i].pix, 1'b1, rows[i].frag);
		end
		rows.delete();

		// ordinary triangle: vertices, interior, far outside, extremes
		load_triangle(place(0, 0, 32'h0001_0000), place(100, 0, 32'h0002_0000),
			place(0, 100, 32'hFFFF_0000), 48'hFFFF_0000_0000, 48'h0000_FFFF_0000,
			48'h0000_0000_FFFF);
		r.typed = 1'b0;
		r.pix = pix(0, 0);           rows.push_back(r);
		r.pix = pix(100, 0);         rows.push_back(r);
		r.pix = pix(0, 100);         rows.push_back(r);
		r.pix = pix(33, 33);         rows.push_back(r);
		r.pix = pix(-50, 170);       rows.push_back(r);
		r.pix = pix(32767, 32767);   rows.push_back(r);
		r.pix = pix(-32768, -32768); rows.push_back(r);
		foreach (rows[i])
			send_pixel(rows[i].pix, 1'b0, rows[i].frag);
		rows.delete();

		// collinear vertices: zero divisor with nonzero edges, colour and depth saturate
		load_triangle(place(-5, -5, 32'h7FFF_FFFF), place(5, 5, 32'h7FFF_FFFF),
			place(20, 20, 32'h8000_0000), 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
			48'hFFFF_FFFF_FFFF);
		r.pix = pix(0, 7);           rows.push_back(r);
		r.pix = pix(20, 20);         rows.push_back(r);
		r.pix = pix(-32768, 32767);  rows.push_back(r);
		r.pix = pix(1, 0);           rows.push_back(r);
		foreach (rows[i])
			send_pixel(rows[i].pix, 1'b0, rows[i].frag);
		rows.delete();

		// extreme register contents
		load_triangle(64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_7FFF_8000,
			64'h7FFF_FFFF_8000_7FFF, 48'hFFFF_FFFF_FFFF, 48'h0, 48'h8000_8000_8000);
		r.pix = pix(0, 0);           rows.push_back(r);
		r.pix = pix(32767, 32767);   rows.push_back(r);
		r.pix = pix(-32768, 0);      rows.push_back(r);
		r.pix = pix(1234, -4321);    rows.push_back(r);
		foreach (rows[i])
			send_pixel(rows[i].pix, 1'b0, rows[i].frag);
		rows.delete();

		// random triangles, mostly small so weights land inside 0..1
		for (int ph = 0; ph < 10; ph++) begin
			mode = $urandom_range(0, 9);
			span = (mode < 6) ? $urandom_range(4, 300) : 32767;
			p0 = {$urandom, $urandom};
			if (mode < 9)
				load_triangle(
					place($urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span,
						$urandom),
					place($urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span,
						$urandom),
					place($urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span,
						$urandom),
					48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
					48'({$urandom, $urandom}));
			else
				load_triangle(p0, p0, {$urandom, $urandom}, 48'({$urandom, $urandom}),
					48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
			no_idle = (ph == 3 || ph == 7);
			if (ph == 5)
				hold_long = 1'b1;
			for (int i = 0; i < 50; i++) begin
				if ($urandom_range(0, 4) == 0)
					r.pix = bfs_pixel_t'($urandom);
				else
					r.pix = pix($urandom_range(0, 2 * span + 40) - span - 20,
						$urandom_range(0, 2 * span + 40) - span - 20);
				send_pixel(r.pix, 1'b0, r.frag);
			end
			pixel_valid <= 1'b0;
			no_idle = 1'b0;
		end

		pixel_valid <= 1'b0;
		drain();
		$display("Covered %0d fragments over %0d register settings, with idle-free stretches",
			n_frags, n_phases);
		$display("and a long output hold-off; %0d mismatches.", n_errors);
		if (n_errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* filelist.f */
src/bfs_pkg.sv
src/bfs_setup.sv
src/bfs_edge.sv
src/bfs_div.sv
src/bfs_blend.sv
src/barycentric_fragment_shade.sv
dv/barycentric_fragment_shade_tb.sv
